### rtl/ssd_pkg.sv
// swept sawtooth decimator: shared types, register indexes and reset constants
// no dependencies; used by every module of the block except ssd_divider
`default_nettype none

package ssd_pkg;

  // field and register widths
  localparam int HR_W        = 20;
  localparam int FREQ_W      = 16;
  localparam int LEN_W       = 20;
  localparam int RATIO_W     = 8;
  localparam int GAIN_W      = 16;
  localparam int SAMPLE_W    = 16;
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_INDEX_W = 3;
  localparam int IN_TDATA_W  = 8;
  localparam int HL_W        = HR_W + LEN_W;        // high_rate * (len - 1)
  localparam int DENP_W      = FREQ_W + LEN_W + 1;  // sum of two frequency products

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_RATE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_START_FREQ   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_END_FREQ     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SWEEP_LENGTH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DECIM_RATIO  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_OUT_LENGTH   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_OUT_GAIN     = 3'd6;

  // register reset values
  localparam logic [HR_W-1:0]    RST_HIGH_RATE    = 20'd192000;
  localparam logic [FREQ_W-1:0]  RST_START_FREQ   = 16'd500;
  localparam logic [FREQ_W-1:0]  RST_END_FREQ     = 16'd3500;
  localparam logic [LEN_W-1:0]   RST_SWEEP_LENGTH = 20'd384000;
  localparam logic [RATIO_W-1:0] RST_DECIM_RATIO  = 8'd24;
  localparam logic [LEN_W-1:0]   RST_OUT_LENGTH   = 20'd16000;
  localparam logic [GAIN_W-1:0]  RST_OUT_GAIN     = 16'd6554;

  // saturation limits of the Q1.15 output
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX     = 16'h7fff;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN     = 16'h8000;
  localparam int unsigned         SAMPLE_NEG_MAG = 32768;

  // divider operand selection
  typedef enum logic [1:0] {
    DIV_SAMPLE,
    DIV_PERIOD,
    DIV_RELOAD
  } ssd_div_sel_e;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SMUL,
    ST_SSTART,
    ST_SWAIT,
    ST_SOUT,
    ST_ADV,
    ST_PMUL,
    ST_PDEN,
    ST_PSTART,
    ST_PWAIT,
    ST_RSTART,
    ST_RWAIT
  } ssd_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic         cfg_write;
    logic         load_prod;
    logic         div_start;
    ssd_div_sel_e div_sel;
    logic         push_out;
    logic         step_decim;
    logic         step_phase;
    logic         load_pmul;
    logic         load_den;
    logic         set_period;
  } ssd_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic run_end;
    logic emit;
    logic idx_zero;
    logic phase_wrap;
    logic out_free;
    logic div_done;
  } ssd_status_t;

endpackage

`default_nettype wire

### rtl/ssd_divider.sv
// iterative restoring divider, one quotient bit per cycle
// standalone; instantiated by ssd_datapath
`default_nettype none

module ssd_divider #(
  parameter int DIVIDEND_W = 40,
  parameter int DIVISOR_W  = 37
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [DIVISOR_W-1:0]  divisor_i,
  output      logic                  done_o,
  output      logic [DIVIDEND_W-1:0] quotient_o,
  output      logic                  rem_nz_o
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]      cnt_q;
  logic                  done_q;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvs_q;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // one restoring step
  always_comb begin
    rem_sh = {rem_q, quo_q[DIVIDEND_W-1]};
    diff   = rem_sh - {1'b0, dvs_q};
    fits   = rem_sh >= {1'b0, dvs_q};
    rem_d  = fits ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
    quo_d  = {quo_q[DIVIDEND_W-2:0], fits};
  end

  // step counter and completion flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(DIVIDEND_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CNT_W'(1);
      done_q <= (cnt_q == CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
  assign rem_nz_o   = |rem_q;

endmodule

`default_nettype wire

### rtl/ssd_datapath.sv
// datapath: config registers, sweep counters, multipliers, shared divider, output register
// depends on ssd_pkg and ssd_divider
`default_nettype none

module ssd_datapath #(
  parameter int COUNT_BITS = 20
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire ssd_pkg::ssd_cmd_t                cmd_i,
  output      ssd_pkg::ssd_status_t             status_o,
  input  wire logic [ssd_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  wire logic [ssd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                             out_ready_i,
  output      logic                             out_valid_o,
  output      logic [ssd_pkg::SAMPLE_W-1:0]     out_sample_o,
  output      logic                             out_last_o
);

  localparam int CB     = COUNT_BITS;
  localparam int CW     = (CB > ssd_pkg::LEN_W) ? CB : ssd_pkg::LEN_W;
  localparam int MAG_W  = CB + 1;
  localparam int PROD_W = MAG_W + ssd_pkg::GAIN_W;
  localparam int DEN_W  = (MAG_W > ssd_pkg::DENP_W) ? MAG_W : ssd_pkg::DENP_W;
  localparam int DIV_W  = (PROD_W > ssd_pkg::HL_W) ? PROD_W : ssd_pkg::HL_W;
  localparam int LW     = ssd_pkg::LEN_W;
  localparam int FW     = ssd_pkg::FREQ_W;

  // reset period, high_rate / start_freq clamped to the counter range
  localparam logic [63:0] RST_QUO = 64'(ssd_pkg::RST_HIGH_RATE) / 64'(ssd_pkg::RST_START_FREQ);
  localparam logic [CB-1:0] RST_PERIOD =
      ((RST_QUO >> CB) != 64'd0) ? {CB{1'b1}} :
      (RST_QUO == 64'd0)         ? CB'(1)     : CB'(RST_QUO);

  // configuration registers
  logic [ssd_pkg::HR_W-1:0]    high_rate_q;
  logic [FW-1:0]               start_freq_q;
  logic [FW-1:0]               end_freq_q;
  logic [LW-1:0]               sweep_length_q;
  logic [ssd_pkg::RATIO_W-1:0] decim_ratio_q;
  logic [LW-1:0]               out_length_q;
  logic [ssd_pkg::GAIN_W-1:0]  out_gain_q;

  // sweep state
  logic [CB-1:0]               n_q;
  logic [CB-1:0]               m_q;
  logic [CB-1:0]               t_q;
  logic [CB-1:0]               oc_q;
  logic [ssd_pkg::RATIO_W-1:0] dc_q;

  // arithmetic registers
  logic [PROD_W-1:0]           prod_q;
  logic                        neg_q;
  logic [ssd_pkg::HL_W-1:0]    hl_q;
  logic [FW+LW-1:0]            ps_q;
  logic [FW+LW-1:0]            pe_q;
  logic [ssd_pkg::DENP_W-1:0]  den_q;

  // output register
  logic                        out_valid_q;
  logic [ssd_pkg::SAMPLE_W-1:0] out_sample_q, out_sample_d;
  logic                        out_last_q, out_last_d;

  // derived values
  logic [CB-1:0]               t_eff;
  logic [CB-1:0]               m1;
  logic [ssd_pkg::RATIO_W-1:0] ratio;
  logic [ssd_pkg::RATIO_W-1:0] dc1;
  logic [CW-1:0]               n_w;
  logic [LW-1:0]               n20;
  logic [LW-1:0]               lm1;
  logic signed [CB+1:0]        diff;
  logic                        diff_neg;
  logic [MAG_W-1:0]            mag;
  logic                        out_free;

  // divider interface
  logic [DIV_W-1:0]            div_dividend;
  logic [DEN_W-1:0]            div_divisor;
  logic                        div_done;
  logic [DIV_W-1:0]            quo;
  logic                        rem_nz;
  logic [DIV_W:0]              mag_n;
  logic [CB-1:0]               period_new;

  // counter helpers
  always_comb begin
    t_eff = (t_q == '0) ? CB'(1) : t_q;
    m1    = m_q + CB'(1);
    ratio = (decim_ratio_q == '0) ? ssd_pkg::RATIO_W'(1) : decim_ratio_q;
    dc1   = dc_q + ssd_pkg::RATIO_W'(1);
    n_w   = CW'(n_q);
    n20   = n_w[LW-1:0];
    lm1   = sweep_length_q - LW'(1);
  end

  // signed sawtooth numerator t - 2m as sign and magnitude
  always_comb begin
    diff     = $signed({2'b00, t_eff}) - $signed({1'b0, m_q, 1'b0});
    diff_neg = diff < 0;
    mag      = diff_neg ? MAG_W'(-diff) : MAG_W'(diff);
  end

  // status toward the controller
  always_comb begin
    status_o.run_end    = ((CW+1)'(oc_q) >= (CW+1)'(out_length_q)) ||
                          ((CW+1)'(n_q) >= (CW+1)'(sweep_length_q));
    status_o.emit       = (dc_q == '0);
    status_o.idx_zero   = (n_q == '0);
    status_o.phase_wrap = (m1 >= t_eff);
    status_o.out_free   = out_free;
    status_o.div_done   = div_done;
  end

  // divider operand selection
  always_comb begin
    div_dividend = DIV_W'(prod_q);
    div_divisor  = DEN_W'({t_eff, 1'b0});
    unique case (cmd_i.div_sel)
      ssd_pkg::DIV_SAMPLE: begin
        div_dividend = DIV_W'(prod_q);
        div_divisor  = DEN_W'({t_eff, 1'b0});
      end
      ssd_pkg::DIV_PERIOD: begin
        div_dividend = DIV_W'(hl_q);
        div_divisor  = DEN_W'(den_q);
      end
      ssd_pkg::DIV_RELOAD: begin
        div_dividend = DIV_W'(high_rate_q);
        div_divisor  = DEN_W'(start_freq_q);
      end
      default: begin
        div_dividend = DIV_W'(prod_q);
        div_divisor  = DEN_W'({t_eff, 1'b0});
      end
    endcase
  end

  ssd_divider #(
    .DIVIDEND_W (DIV_W),
    .DIVISOR_W  (DEN_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (quo),
    .rem_nz_o   (rem_nz)
  );

  // floor of the signed quotient, saturated to Q1.15, and the last flag
  always_comb begin
    mag_n = {1'b0, quo} + (DIV_W+1)'(rem_nz);
    if (neg_q) begin
      if (mag_n > (DIV_W+1)'(ssd_pkg::SAMPLE_NEG_MAG)) begin
        out_sample_d = ssd_pkg::SAMPLE_MIN;
      end else begin
        out_sample_d = ssd_pkg::SAMPLE_W'(0) - mag_n[ssd_pkg::SAMPLE_W-1:0];
      end
    end else if (|quo[DIV_W-1:ssd_pkg::SAMPLE_W-1]) begin
      out_sample_d = ssd_pkg::SAMPLE_MAX;
    end else begin
      out_sample_d = quo[ssd_pkg::SAMPLE_W-1:0];
    end
    out_last_d = (((CW+1)'(oc_q) + (CW+1)'(1)) >= (CW+1)'(out_length_q)) ||
                 (((CW+1)'(n_q) + (CW+1)'(ratio)) >= (CW+1)'(sweep_length_q));
  end

  // period clamp to 1 .. 2^COUNT_BITS-1
  always_comb begin
    if (|quo[DIV_W-1:CB]) begin
      period_new = {CB{1'b1}};
    end else if (quo[CB-1:0] == '0) begin
      period_new = CB'(1);
    end else begin
      period_new = quo[CB-1:0];
    end
  end

  // configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_rate_q    <= ssd_pkg::RST_HIGH_RATE;
      start_freq_q   <= ssd_pkg::RST_START_FREQ;
      end_freq_q     <= ssd_pkg::RST_END_FREQ;
      sweep_length_q <= ssd_pkg::RST_SWEEP_LENGTH;
      decim_ratio_q  <= ssd_pkg::RST_DECIM_RATIO;
      out_length_q   <= ssd_pkg::RST_OUT_LENGTH;
      out_gain_q     <= ssd_pkg::RST_OUT_GAIN;
    end else if (cmd_i.cfg_write) begin
      unique case (cfg_index_i)
        ssd_pkg::REG_HIGH_RATE:    high_rate_q    <= cfg_data_i[ssd_pkg::HR_W-1:0];
        ssd_pkg::REG_START_FREQ:   start_freq_q   <= cfg_data_i[FW-1:0];
        ssd_pkg::REG_END_FREQ:     end_freq_q     <= cfg_data_i[FW-1:0];
        ssd_pkg::REG_SWEEP_LENGTH: sweep_length_q <= cfg_data_i[LW-1:0];
        ssd_pkg::REG_DECIM_RATIO:  decim_ratio_q  <= cfg_data_i[ssd_pkg::RATIO_W-1:0];
        ssd_pkg::REG_OUT_LENGTH:   out_length_q   <= cfg_data_i[LW-1:0];
        ssd_pkg::REG_OUT_GAIN:     out_gain_q     <= cfg_data_i[ssd_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // sweep counters and period
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q  <= '0;
      m_q  <= '0;
      t_q  <= RST_PERIOD;
      oc_q <= '0;
      dc_q <= '0;
    end else begin
      if (cmd_i.push_out) begin
        oc_q <= oc_q + CB'(1);
      end
      if (cmd_i.step_decim) begin
        dc_q <= (dc1 >= ratio) ? '0 : dc1;
      end
      if (cmd_i.step_phase) begin
        m_q <= status_o.phase_wrap ? '0 : m1;
        n_q <= n_q + CB'(1);
      end
      if (cmd_i.set_period) begin
        t_q <= period_new;
      end
    end
  end

  // multiplier and denominator registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_prod) begin
      prod_q <= PROD_W'(mag) * PROD_W'(out_gain_q);
      neg_q  <= diff_neg;
    end
    if (cmd_i.load_pmul) begin
      hl_q <= ssd_pkg::HL_W'(high_rate_q) * ssd_pkg::HL_W'(lm1);
      ps_q <= (FW+LW)'(start_freq_q) * (FW+LW)'(lm1 - n20);
      pe_q <= (FW+LW)'(end_freq_q) * (FW+LW)'(n20);
    end
    if (cmd_i.load_den) begin
      den_q <= ssd_pkg::DENP_W'(ps_q) + ssd_pkg::DENP_W'(pe_q);
    end
  end

  // output register, frees when the receiver takes the request
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_out) begin
      out_sample_q <= out_sample_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign out_last_o   = out_last_q;

endmodule

`default_nettype wire

### rtl/ssd_ctrl.sv
// controller state machine: sequences ticks, period updates and config reloads
// depends on ssd_pkg; drives ssd_datapath through command and status structs
`default_nettype none

module ssd_ctrl (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            tick_valid_i,
  input  wire logic                            tick_i,
  output      logic                            tick_ready_o,
  input  wire logic                            cfg_valid_i,
  input  wire logic [ssd_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  output      logic                            cfg_ready_o,
  input  wire ssd_pkg::ssd_status_t            status_i,
  output      ssd_pkg::ssd_cmd_t               cmd_o
);

  ssd_pkg::ssd_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.div_sel  = ssd_pkg::DIV_SAMPLE;
    tick_ready_o   = 1'b0;
    cfg_ready_o    = 1'b0;
    unique case (state_q)
      ssd_pkg::ST_IDLE: begin
        cfg_ready_o  = 1'b1;
        tick_ready_o = !cfg_valid_i;
        if (cfg_valid_i) begin
          // known register: write, and reload the period before the sweep starts
          if (cfg_index_i <= ssd_pkg::REG_OUT_GAIN) begin
            cmd_o.cfg_write = 1'b1;
            if (status_i.idx_zero) begin
              state_d = ssd_pkg::ST_RSTART;
            end
          end
        end else if (tick_valid_i && tick_i && !status_i.run_end) begin
          state_d = status_i.emit ? ssd_pkg::ST_SMUL : ssd_pkg::ST_ADV;
        end
      end
      ssd_pkg::ST_SMUL: begin
        cmd_o.load_prod = 1'b1;
        state_d         = ssd_pkg::ST_SSTART;
      end
      ssd_pkg::ST_SSTART: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = ssd_pkg::DIV_SAMPLE;
        state_d         = ssd_pkg::ST_SWAIT;
      end
      ssd_pkg::ST_SWAIT: begin
        if (status_i.div_done) begin
          state_d = ssd_pkg::ST_SOUT;
        end
      end
      ssd_pkg::ST_SOUT: begin
        // hold until the output register has room
        if (status_i.out_free) begin
          cmd_o.push_out = 1'b1;
          state_d        = ssd_pkg::ST_ADV;
        end
      end
      ssd_pkg::ST_ADV: begin
        cmd_o.step_decim = 1'b1;
        if (status_i.phase_wrap) begin
          state_d = ssd_pkg::ST_PMUL;
        end else begin
          cmd_o.step_phase = 1'b1;
          state_d          = ssd_pkg::ST_IDLE;
        end
      end
      ssd_pkg::ST_PMUL: begin
        cmd_o.load_pmul = 1'b1;
        state_d         = ssd_pkg::ST_PDEN;
      end
      ssd_pkg::ST_PDEN: begin
        cmd_o.load_den = 1'b1;
        state_d        = ssd_pkg::ST_PSTART;
      end
      ssd_pkg::ST_PSTART: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = ssd_pkg::DIV_PERIOD;
        state_d         = ssd_pkg::ST_PWAIT;
      end
      ssd_pkg::ST_PWAIT: begin
        if (status_i.div_done) begin
          cmd_o.set_period = 1'b1;
          cmd_o.step_phase = 1'b1;
          state_d          = ssd_pkg::ST_IDLE;
        end
      end
      ssd_pkg::ST_RSTART: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = ssd_pkg::DIV_RELOAD;
        state_d         = ssd_pkg::ST_RWAIT;
      end
      ssd_pkg::ST_RWAIT: begin
        if (status_i.div_done) begin
          cmd_o.set_period = 1'b1;
          state_d          = ssd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ssd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/swept_sawtooth_decimator.sv
// Linear-chirp sawtooth generator with decimation and gain, Q1.15 output.
// Each request on the slave stream carries one tick (tdata bit 0); a tick of
// one advances the sweep by one high-rate sample. Every decim_ratio-th active
// tick, starting with the first, sends one sample on the master stream, with
// tlast on the final one; after out_length samples or sweep_length ticks the
// block ignores further ticks.
// Config channel: cfg_index_i selects a register (0..6, others ignored),
// cfg_data_i holds its value. While the sweep index is still zero, a write
// also reloads the period as high_rate / start_freq, which keeps the block
// busy until the divider finishes. A tick that emits a sample waits for a
// division in the divider; a tick that ends a sawtooth period adds a period
// division through the same divider. The divider runs one step per dividend
// bit, max(COUNT_BITS+17, 40) bits.
// One finished sample waits in the output register; the next tick is accepted
// meanwhile and only stalls at its own sample if the receiver is still busy.
// Reset restores the register defaults and restarts the sweep from zero.
`default_nettype none

module swept_sawtooth_decimator #(
  parameter int COUNT_BITS = 20
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // slave stream, tdata: [0] tick, [7:1] zero
  input  wire logic                             s_axis_tvalid,
  output      logic                             s_axis_tready,
  input  wire logic [ssd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // master stream, tdata: [15:0] sample_out; tlast: last_out
  output      logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output      logic [ssd_pkg::SAMPLE_W-1:0]     m_axis_tdata,
  output      logic                             m_axis_tlast,
  // config write channel
  input  wire logic                             cfg_valid_i,
  output      logic                             cfg_ready_o,
  input  wire logic [ssd_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  wire logic [ssd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  ssd_pkg::ssd_cmd_t    cmd;
  ssd_pkg::ssd_status_t status;

  // sequencing
  ssd_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_valid_i (s_axis_tvalid),
    .tick_i       (s_axis_tdata[0]),
    .tick_ready_o (s_axis_tready),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_ready_o  (cfg_ready_o),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  // arithmetic and state
  ssd_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_sample_o (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule

`default_nettype wire
